### design/hc_pkg.sv
// Package for the table-driven Huffman codec.
// Holds default sizes, the action and register codes and the sequencer state type.
// No dependencies.
`default_nettype none

package hc_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned TABLE_DEPTH_DEF   = 256;
  localparam int unsigned MAX_CODE_BITS_DEF = 32;

  // Action codes carried by an input transfer.
  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_DATA = 2'd1,
    ACT_END  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_MODE    = 1'b0,
    REG_ENTRIES = 1'b1
  } reg_e;

  // Mode register values.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC_BIT,
    ST_SCAN,
    ST_ENC_SHIFT,
    ST_DEC_EMIT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

### design/hc_in_if.sv
// Input channel of the Huffman codec: valid/ready handshake and item payload.
// No dependencies.
`default_nettype none

interface hc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  entry_index;
  logic [7:0]  entry_symbol;
  logic [5:0]  entry_length;
  logic [31:0] entry_code;
  logic [7:0]  data_value;

  modport source (output valid, action, entry_index, entry_symbol, entry_length,
                  entry_code, data_value, input ready);
  modport sink   (input valid, action, entry_index, entry_symbol, entry_length,
                  entry_code, data_value, output ready);
endinterface

`default_nettype wire

### design/hc_out_if.sv
// Output channel of the Huffman codec: valid/ready handshake and result payload.
// No dependencies.
`default_nettype none

interface hc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       last;

  modport source (output valid, out_value, last, input ready);
  modport sink   (input valid, out_value, last, output ready);
endinterface

`default_nettype wire

### design/hc_table_mem.sv
// Code table storage: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module hc_table_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 46
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/hc_match.sv
// Shared entry compare unit: symbol match when encoding, length and code match
// when decoding. Depends on hc_pkg.
`default_nettype none

module hc_match #(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned LEN_W         = 6
) (
  input  wire logic                     mode_i,
  input  wire logic [7:0]               symbol_i,
  input  wire logic [MAX_CODE_BITS-1:0] acc_i,
  input  wire logic [LEN_W-1:0]         cnt_i,
  input  wire logic [7:0]               ent_symbol_i,
  input  wire logic [LEN_W-1:0]         ent_length_i,
  input  wire logic [MAX_CODE_BITS-1:0] ent_code_i,
  output logic                          hit_o
);
  import hc_pkg::*;

  logic [MAX_CODE_BITS-1:0] len_mask;

  // Keep only the low length bits of the code; a full-width length keeps all.
  assign len_mask = ~({MAX_CODE_BITS{1'b1}} << ent_length_i);

  always_comb begin
    if (mode_i == MODE_DECODE) begin
      hit_o = (ent_length_i == cnt_i) && ((ent_code_i & len_mask) == acc_i);
    end else begin
      hit_o = (ent_symbol_i == symbol_i);
    end
  end

endmodule

`default_nettype wire

### design/hc_engine.sv
// Codec sequencer: scans the code table one entry per cycle through the shared
// compare unit, packs or gathers bits, and drives the output register.
// Depends on hc_pkg, hc_in_if, hc_out_if, hc_table_mem and hc_match.
`default_nettype none

module hc_engine #(
  parameter int unsigned TABLE_DEPTH   = 256,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               mode_i,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]   lim_i,
  hc_in_if.sink                                   in_ch,
  hc_out_if.source                                out_ch
);
  import hc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LEN_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned DATA_W = 8 + LEN_W + MAX_CODE_BITS;

  state_e state_q, state_d;

  logic [CNT_W-1:0]         e_q, e_d;
  logic                     rd_pend_q, rd_pend_d;
  logic [7:0]               data_q, data_d;
  logic [2:0]               bit_idx_q, bit_idx_d;
  logic [MAX_CODE_BITS-1:0] acc_q, acc_d;
  logic [LEN_W-1:0]         cnt_q, cnt_d;
  logic [7:0]               pack_q, pack_d;
  logic [2:0]               pcnt_q, pcnt_d;
  logic [MAX_CODE_BITS-1:0] code_q, code_d;
  logic [LEN_W-1:0]         rem_q, rem_d;
  logic [7:0]               sym_q, sym_d;
  logic                     pres_v_q, pres_v_d;
  logic [7:0]               pres_q, pres_d;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_value_q, out_value_d;
  logic                     out_last_q, out_last_d;

  logic                     accept, out_free, can_emit, hit, scan_issue, scan_miss;
  logic                     enc_step, mem_we;
  logic [LEN_W-1:0]         load_len;
  logic [DATA_W-1:0]        rdata;
  logic [7:0]               rd_sym;
  logic [LEN_W-1:0]         rd_len;
  logic [MAX_CODE_BITS-1:0] rd_code;
  logic                     match_hit;
  logic [7:0]               pack_n;

  // Handshake and sequencing conditions.
  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;
  assign can_emit    = !pres_v_q || out_free;
  assign hit         = (state_q == ST_SCAN) && rd_pend_q && match_hit;
  assign scan_issue  = (state_q == ST_SCAN) && !hit && (e_q < lim_i);
  assign scan_miss   = (state_q == ST_SCAN) && !rd_pend_q && (e_q >= lim_i);
  assign pack_n      = {pack_q[6:0], code_q[MAX_CODE_BITS-1]};
  assign enc_step    = (pcnt_q != 3'd7) || can_emit;

  assign out_ch.valid     = out_valid_q;
  assign out_ch.out_value = out_value_q;
  assign out_ch.last      = out_last_q;

  // Table load: lengths saturate, slots beyond the table are dropped.
  assign load_len = (in_ch.entry_length > 6'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                              : LEN_W'(in_ch.entry_length);
  assign mem_we   = accept && (in_ch.action == ACT_LOAD)
                    && ({1'b0, in_ch.entry_index} < 9'(TABLE_DEPTH));

  hc_table_mem #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_ch.entry_index[IDX_W-1:0]),
    .wdata_i ({in_ch.entry_symbol, load_len, in_ch.entry_code[MAX_CODE_BITS-1:0]}),
    .re_i    (scan_issue),
    .raddr_i (e_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign rd_sym  = rdata[DATA_W-1 -: 8];
  assign rd_len  = rdata[MAX_CODE_BITS +: LEN_W];
  assign rd_code = rdata[MAX_CODE_BITS-1:0];

  hc_match #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .LEN_W         (LEN_W)
  ) u_match (
    .mode_i       (mode_i),
    .symbol_i     (data_q),
    .acc_i        (acc_q),
    .cnt_i        (cnt_q),
    .ent_symbol_i (rd_sym),
    .ent_length_i (rd_len),
    .ent_code_i   (rd_code),
    .hit_o        (match_hit)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_ch.action == ACT_DATA)) begin
          state_d = (mode_i == MODE_DECODE) ? ST_DEC_BIT : ST_SCAN;
        end else if (accept && (in_ch.action == ACT_END) && (mode_i == MODE_ENCODE)
                     && (pcnt_q != 3'd0)) begin
          state_d = ST_FINISH;
        end
      end
      ST_DEC_BIT: state_d = ST_SCAN;
      ST_SCAN: begin
        if (hit) begin
          if (mode_i == MODE_DECODE) begin
            state_d = ST_DEC_EMIT;
          end else begin
            state_d = (rd_len == '0) ? ST_FINISH : ST_ENC_SHIFT;
          end
        end else if (scan_miss) begin
          if (mode_i == MODE_DECODE && bit_idx_q != 3'd0) begin
            state_d = ST_DEC_BIT;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_ENC_SHIFT: begin
        if (enc_step && rem_q == LEN_W'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_DEC_EMIT: begin
        if (can_emit) begin
          state_d = (bit_idx_q == 3'd0) ? ST_FINISH : ST_DEC_BIT;
        end
      end
      ST_FINISH: begin
        if (can_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    e_d         = e_q;
    rd_pend_d   = scan_issue;
    data_d      = data_q;
    bit_idx_d   = bit_idx_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    pack_d      = pack_q;
    pcnt_d      = pcnt_q;
    code_d      = code_q;
    rem_d       = rem_q;
    sym_d       = sym_q;
    pres_v_d    = pres_v_q;
    pres_d      = pres_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_ch.action == ACT_DATA)) begin
          data_d    = in_ch.data_value;
          e_d       = '0;
          bit_idx_d = 3'd7;
        end else if (accept && (in_ch.action == ACT_END)) begin
          if (mode_i == MODE_DECODE) begin
            acc_d = '0;
            cnt_d = '0;
          end else if (pcnt_q != 3'd0) begin
            // Flush the partial byte, zero padded in its low bits.
            pres_v_d = 1'b1;
            pres_d   = pack_q << (4'd8 - {1'b0, pcnt_q});
            pack_d   = '0;
            pcnt_d   = '0;
          end
        end
      end
      ST_DEC_BIT: begin
        acc_d  = {acc_q[MAX_CODE_BITS-2:0], data_q[7]};
        data_d = {data_q[6:0], 1'b0};
        cnt_d  = cnt_q + LEN_W'(1);
        e_d    = '0;
      end
      ST_SCAN: begin
        if (scan_issue) begin
          e_d = e_q + CNT_W'(1);
        end
        if (hit) begin
          sym_d  = rd_sym;
          code_d = rd_code << (LEN_W'(MAX_CODE_BITS) - rd_len);
          rem_d  = rd_len;
        end else if (scan_miss && mode_i == MODE_DECODE) begin
          if (cnt_q >= LEN_W'(MAX_CODE_BITS)) begin
            acc_d = '0;
            cnt_d = '0;
          end
          bit_idx_d = bit_idx_q - 3'd1;
        end
      end
      ST_ENC_SHIFT: begin
        if (enc_step) begin
          code_d = code_q << 1;
          rem_d  = rem_q - LEN_W'(1);
          if (pcnt_q == 3'd7) begin
            if (pres_v_q) begin
              out_valid_d = 1'b1;
              out_value_d = pres_q;
              out_last_d  = 1'b0;
            end
            pres_v_d = 1'b1;
            pres_d   = pack_n;
            pack_d   = '0;
            pcnt_d   = '0;
          end else begin
            pack_d = pack_n;
            pcnt_d = pcnt_q + 3'd1;
          end
        end
      end
      ST_DEC_EMIT: begin
        if (can_emit) begin
          if (pres_v_q) begin
            out_valid_d = 1'b1;
            out_value_d = pres_q;
            out_last_d  = 1'b0;
          end
          pres_v_d  = 1'b1;
          pres_d    = sym_q;
          acc_d     = '0;
          cnt_d     = '0;
          bit_idx_d = bit_idx_q - 3'd1;
        end
      end
      ST_FINISH: begin
        // The held result is the last one of this item.
        if (pres_v_q && out_free) begin
          out_valid_d = 1'b1;
          out_value_d = pres_q;
          out_last_d  = 1'b1;
          pres_v_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      e_q         <= '0;
      rd_pend_q   <= 1'b0;
      bit_idx_q   <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      pack_q      <= '0;
      pcnt_q      <= '0;
      rem_q       <= '0;
      pres_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      e_q         <= e_d;
      rd_pend_q   <= rd_pend_d;
      bit_idx_q   <= bit_idx_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      pack_q      <= pack_d;
      pcnt_q      <= pcnt_d;
      rem_q       <= rem_d;
      pres_v_q    <= pres_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    data_q      <= data_d;
    code_q      <= code_d;
    sym_q       <= sym_d;
    pres_q      <= pres_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

endmodule

`default_nettype wire

### design/table_huffman_codec_top.sv
// A load, an ignored action or an end of message without a flush leaves the sequencer
// idle; a flush passes through the finish state. Encoding scans the table for the
// symbol, then shifts out its code bits; a symbol not found ends the scan at the entry
// limit. Decoding shifts in each bit of the byte and scans the table after it, emitting
// a symbol on a match. One item at a time; result stalls add cycles.
// Reset clears all control state; table contents are undefined until loaded.
`default_nettype none

module table_huffman_codec_top #(
  parameter int unsigned TABLE_DEPTH   = hc_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_CODE_BITS = hc_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  hc_in_if.sink            in_ch,
  hc_out_if.source         out_ch
);
  import hc_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             mode_q;
  logic [8:0]       entries_q;
  logic [CNT_W-1:0] lim;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_ENCODE;
      entries_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_MODE:    mode_q    <= pwdata[0];
        REG_ENTRIES: entries_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_MODE:    prdata = {31'd0, mode_q};
      REG_ENTRIES: prdata = {23'd0, entries_q};
      default:     prdata = '0;
    endcase
  end

  // Scan limit saturates at the table depth.
  assign lim = (entries_q > 9'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_q);

  hc_engine #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .lim_i  (lim),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### design/hc_checker.sv
// Port-level checker for the Huffman codec and its bind to the top level.
// Depends on hc_pkg and table_huffman_codec_top.
`default_nettype none

module hc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_action,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_value,
  input wire logic       out_last
);
  import hc_pkg::*;

  // A data transfer moves the sequencer out of idle, so input ready drops.
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_action == ACT_DATA |=> !in_ready)
    else $error("input ready stayed high after a data transfer");

  // A table load finishes at once.
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_action == ACT_LOAD |=> in_ready)
    else $error("input ready dropped after a table load");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
    else $error("result payload changed while stalled");

endmodule

bind table_huffman_codec_top hc_checker u_hc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.out_value),
  .out_last  (out_ch.last)
);

`default_nettype wire
